@@ src/sit_pkg.sv @@
// Shared types and constants for the shape intersection test.
package sit_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ACTION_WIDTH = 3;

	typedef enum logic [ACTION_WIDTH-1:0] {
		ACT_BOX_BOX       = 3'd0,
		ACT_BOX_CIRCLE    = 3'd1,
		ACT_CIRCLE_CIRCLE = 3'd2,
		ACT_BOX_POINT     = 3'd3,
		ACT_CIRCLE_POINT  = 3'd4
	} action_t;

	typedef struct packed {
		logic decided;
		logic dec_hit;
		logic strict;
	} ctl_t;

endpackage

@@ src/sit_prep.sv @@
// Operand preparation: differences, early box decisions and squarer operands.
module sit_prep
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic [ACTION_WIDTH-1:0]        action,
	input  logic signed [COORD_WIDTH-1:0]  a_left,
	input  logic signed [COORD_WIDTH-1:0]  a_top,
	input  logic signed [COORD_WIDTH-1:0]  a_right,
	input  logic signed [COORD_WIDTH-1:0]  a_bottom,
	input  logic signed [COORD_WIDTH-1:0]  b_left,
	input  logic signed [COORD_WIDTH-1:0]  b_top,
	input  logic signed [COORD_WIDTH-1:0]  b_right,
	input  logic signed [COORD_WIDTH-1:0]  b_bottom,
	output logic [COORD_WIDTH+1:0]         op0,
	output logic [COORD_WIDTH+1:0]         op1,
	output logic [COORD_WIDTH+1:0]         op2,
	output ctl_t                           ctl
);

	localparam int E = COORD_WIDTH + 3;
	localparam int M = COORD_WIDTH + 2;

	function automatic logic [M-1:0] mag_e(input logic signed [E-1:0] v);
		logic [E-1:0] u;
		u = v[E-1] ? -v : v;
		return u[M-1:0];
	endfunction

	logic signed [E-1:0] al_e, at_e, ar_e, ab_e, bl_e, bt_e, br_e;
	logic signed [E-1:0] sx, sy, dx, dy, hx, hy, rr, ex, ey, d0, d1, rs;
	logic bb_hit, bp_hit, bc_far, bc_in;

	assign al_e = {{3{a_left[COORD_WIDTH-1]}}, a_left};
	assign at_e = {{3{a_top[COORD_WIDTH-1]}}, a_top};
	assign ar_e = {{3{a_right[COORD_WIDTH-1]}}, a_right};
	assign ab_e = {{3{a_bottom[COORD_WIDTH-1]}}, a_bottom};
	assign bl_e = {{3{b_left[COORD_WIDTH-1]}}, b_left};
	assign bt_e = {{3{b_top[COORD_WIDTH-1]}}, b_top};
	assign br_e = {{3{b_right[COORD_WIDTH-1]}}, b_right};

	// Box-circle runs in doubled units so the box centre is exact.
	assign sx = al_e + ar_e - (bl_e <<< 1);
	assign sy = at_e + ab_e - (bt_e <<< 1);
	assign dx = signed'({1'b0, mag_e(sx)});
	assign dy = signed'({1'b0, mag_e(sy)});
	assign hx = ar_e - al_e;
	assign hy = ab_e - at_e;
	assign rr = br_e <<< 1;
	assign ex = dx - hx;
	assign ey = dy - hy;
	assign bc_far = (dx > hx + rr) || (dy > hy + rr);
	assign bc_in = (dx <= hx) || (dy <= hy);

	assign d0 = bl_e - al_e;
	assign d1 = bt_e - at_e;
	assign rs = ar_e + br_e;

	assign bb_hit = !(a_right < b_left || b_right < a_left ||
		a_bottom < b_top || b_bottom < a_top);
	assign bp_hit = (a_left < b_left) && (a_right > b_left) &&
		(a_top < b_top) && (a_bottom > b_top);

	always_comb begin
		op0 = '0;
		op1 = '0;
		op2 = '0;
		ctl = '{decided: 1'b1, dec_hit: 1'b0, strict: 1'b0};
		case (action_t'(action))
			ACT_BOX_BOX: begin
				ctl.dec_hit = bb_hit;
			end
			ACT_BOX_CIRCLE: begin
				op0 = mag_e(ex);
				op1 = mag_e(ey);
				op2 = mag_e(rr);
				ctl.decided = bc_far || bc_in;
				ctl.dec_hit = !bc_far;
			end
			ACT_CIRCLE_CIRCLE: begin
				op0 = mag_e(d0);
				op1 = mag_e(d1);
				op2 = mag_e(rs);
				ctl.decided = 1'b0;
				ctl.strict = 1'b1;
			end
			ACT_BOX_POINT: begin
				ctl.dec_hit = bp_hit;
			end
			ACT_CIRCLE_POINT: begin
				op0 = mag_e(d0);
				op1 = mag_e(d1);
				op2 = mag_e(ar_e);
				ctl.decided = 1'b0;
			end
			default: begin
				ctl.dec_hit = 1'b0;
			end
		endcase
	end

endmodule

@@ src/shape_intersection_test.sv @@
// Top level of the shape intersection test: input register, squarers, compare.
// An accepted item goes through the operand and square registers into the result register.
// Throughput is one item per cycle while out_stall does not hold the pipe; stages are input, operands, squares, result.
// Each stage holds its item when the stage after it is full and cannot move.
// Reset clears the stage valid flags; payload registers are not reset.
module shape_intersection_test
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ACTION_WIDTH-1:0]        action,
	input  logic signed [COORD_WIDTH-1:0]  a_left,
	input  logic signed [COORD_WIDTH-1:0]  a_top,
	input  logic signed [COORD_WIDTH-1:0]  a_right,
	input  logic signed [COORD_WIDTH-1:0]  a_bottom,
	input  logic signed [COORD_WIDTH-1:0]  b_left,
	input  logic signed [COORD_WIDTH-1:0]  b_top,
	input  logic signed [COORD_WIDTH-1:0]  b_right,
	input  logic signed [COORD_WIDTH-1:0]  b_bottom,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit
);

	localparam int M = COORD_WIDTH + 2;
	localparam int SQ = 2 * M;

	logic v_s1, v_s2, v_s3;
	logic take1, take2, take3, take_out;

	logic [ACTION_WIDTH-1:0]       action_s1;
	logic signed [COORD_WIDTH-1:0] al_s1, at_s1, ar_s1, ab_s1, bl_s1, bt_s1, br_s1, bb_s1;

	logic [M-1:0] op0, op1, op2;
	ctl_t ctl;
	logic [M-1:0] op0_s2, op1_s2, op2_s2;
	ctl_t ctl_s2;

	logic [SQ-1:0] sq0_s3, sq1_s3, sq2_s3;
	ctl_t ctl_s3;

	logic [SQ:0] sum;
	logic hit_d;

	assign take_out = !out_valid || !out_stall;
	assign take3 = !v_s3 || take_out;
	assign take2 = !v_s2 || take3;
	assign take1 = !v_s1 || take2;
	assign in_stall = !take1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take1) v_s1 <= in_valid;
			if (take2) v_s2 <= v_s1;
			if (take3) v_s3 <= v_s2;
			if (take_out) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			action_s1 <= action;
			al_s1 <= a_left;
			at_s1 <= a_top;
			ar_s1 <= a_right;
			ab_s1 <= a_bottom;
			bl_s1 <= b_left;
			bt_s1 <= b_top;
			br_s1 <= b_right;
			bb_s1 <= b_bottom;
		end
		if (take2) begin
			op0_s2 <= op0;
			op1_s2 <= op1;
			op2_s2 <= op2;
			ctl_s2 <= ctl;
		end
		if (take3) begin
			sq0_s3 <= SQ'(op0_s2) * SQ'(op0_s2);
			sq1_s3 <= SQ'(op1_s2) * SQ'(op1_s2);
			sq2_s3 <= SQ'(op2_s2) * SQ'(op2_s2);
			ctl_s3 <= ctl_s2;
		end
		if (take_out) hit <= hit_d;
	end

	sit_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.action   (action_s1),
		.a_left   (al_s1),
		.a_top    (at_s1),
		.a_right  (ar_s1),
		.a_bottom (ab_s1),
		.b_left   (bl_s1),
		.b_top    (bt_s1),
		.b_right  (br_s1),
		.b_bottom (bb_s1),
		.op0      (op0),
		.op1      (op1),
		.op2      (op2),
		.ctl      (ctl)
	);

	assign sum = {1'b0, sq0_s3} + {1'b0, sq1_s3};

	always_comb begin
		if (ctl_s3.decided) begin
			hit_d = ctl_s3.dec_hit;
		end else if (ctl_s3.strict) begin
			hit_d = sum < {1'b0, sq2_s3};
		end else begin
			hit_d = sum <= {1'b0, sq2_s3};
		end
	end

	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled while the first stage is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item did not reach the first stage");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_valid) |=> out_valid)
		else $error("squared item did not move into an empty result register");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && out_valid && out_stall) |=> (v_s2 && $stable(ctl_s2)))
		else $error("operand stage changed while the pipe was blocked");

endmodule

@@ dv/shape_intersection_test_tb.sv @@
// Self-checking testbench for the two-shape intersection test: directed and random pairs.
`timescale 1ns / 1ps

import sit_pkg::*;

localparam int CW = COORD_WIDTH_DEF;
localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_LO = 3'd5;
localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_HI = 3'd7;

typedef struct packed {
	logic [ACTION_WIDTH-1:0] action;
	logic signed [CW-1:0] a_left;
	logic signed [CW-1:0] a_top;
	logic signed [CW-1:0] a_right;
	logic signed [CW-1:0] a_bottom;
	logic signed [CW-1:0] b_left;
	logic signed [CW-1:0] b_top;
	logic signed [CW-1:0] b_right;
	logic signed [CW-1:0] b_bottom;
} shape_pair_t;

class hit_scoreboard;
	bit pending_hits[$];
	logic [ACTION_WIDTH-1:0] pending_actions[$];
	int checked;
	int mismatches;
	int hits_seen;
	int per_action[8];

	function new();
		checked = 0;
		mismatches = 0;
		hits_seen = 0;
		foreach (per_action[i]) per_action[i] = 0;
	endfunction

	function bit predict_hit(shape_pair_t p);
		longint al, at, ar, ab, bl, bt, br, bb;
		longint dx, dy, hx, hy, rr, ex, ey;
		al = longint'($signed(p.a_left));
		at = longint'($signed(p.a_top));
		ar = longint'($signed(p.a_right));
		ab = longint'($signed(p.a_bottom));
		bl = longint'($signed(p.b_left));
		bt = longint'($signed(p.b_top));
		br = longint'($signed(p.b_right));
		bb = longint'($signed(p.b_bottom));
		case (p.action)
			ACT_BOX_BOX: begin
				return !(ar < bl || br < al || ab < bt || bb < at);
			end
			ACT_BOX_CIRCLE: begin
				// Doubled units keep the box center and half extent exact.
				dx = (al + ar) - 2 * bl;
				dy = (at + ab) - 2 * bt;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				hx = ar - al;
				hy = ab - at;
				rr = 2 * br;
				if (dx > hx + rr || dy > hy + rr) return 1'b0;
				if (dx <= hx || dy <= hy) return 1'b1;
				ex = dx - hx;
				ey = dy - hy;
				return ex * ex + ey * ey <= rr * rr;
			end
			ACT_CIRCLE_CIRCLE: begin
				ex = bl - al;
				ey = bt - at;
				rr = ar + br;
				return ex * ex + ey * ey < rr * rr;
			end
			ACT_BOX_POINT: begin
				return al < bl && ar > bl && at < bt && ab > bt;
			end
			ACT_CIRCLE_POINT: begin
				ex = bl - al;
				ey = bt - at;
				return ex * ex + ey * ey <= ar * ar;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function void note_pair(shape_pair_t p);
		pending_hits.push_back(predict_hit(p));
		pending_actions.push_back(p.action);
		per_action[p.action]++;
	endfunction

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH: %s", what);
	endfunction

	function void check_hit(logic actual);
		bit want;
		logic [ACTION_WIDTH-1:0] act;
		if (pending_hits.size() == 0) begin
			flag($sformatf("result hit=%b arrived with no item outstanding", actual));
			return;
		end
		want = pending_hits.pop_front();
		act = pending_actions.pop_front();
		checked++;
		if (actual === 1'b1) hits_seen++;
		if (actual !== want)
			flag($sformatf("result %0d action %0d: hit expected %b, got %b",
				checked, act, want, actual));
	endfunction

	function int pending_count();
		return pending_hits.size();
	endfunction

	function void drain_leftovers();
		while (pending_hits.size() != 0) begin
			flag($sformatf("no result for an item with action %0d", pending_actions[0]));
			void'(pending_hits.pop_front());
			void'(pending_actions.pop_front());
		end
	endfunction
endclass

module testbench;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ACTION_WIDTH-1:0] action;
	logic signed [CW-1:0] a_left, a_top, a_right, a_bottom;
	logic signed [CW-1:0] b_left, b_top, b_right, b_bottom;
	logic out_valid;
	logic out_stall;
	logic hit;

	int send_idle_pct;
	int recv_idle_pct;
	hit_scoreboard board;

	shape_intersection_test #(
		.COORD_WIDTH(CW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.a_left(a_left),
		.a_top(a_top),
		.a_right(a_right),
		.a_bottom(a_bottom),
		.b_left(b_left),
		.b_top(b_top),
		.b_right(b_right),
		.b_bottom(b_bottom),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d items still outstanding.", board.pending_count());
		$display("shape_intersection_test test failed");
		$finish;
	end

	// Receiver side: stall decided at the falling edge, results taken at the rising edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_hit(hit);
	end

	function automatic logic signed [CW-1:0] near(int base, int span);
		int v;
		v = base + int'($urandom_range(0, 2 * span)) - span;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[CW-1:0];
	endfunction

	function automatic shape_pair_t make_pair();
		shape_pair_t p;
		int cx, cy, sz;
		if ($urandom_range(0, 99) < 6)
			p.action = ACTION_WIDTH'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		else
			p.action = ACTION_WIDTH'($urandom_range(ACT_BOX_BOX, ACT_CIRCLE_POINT));
		if ($urandom_range(0, 99) < 15) begin
			p.a_left = CW'($urandom);
			p.a_top = CW'($urandom);
			p.a_right = CW'($urandom);
			p.a_bottom = CW'($urandom);
			p.b_left = CW'($urandom);
			p.b_top = CW'($urandom);
			p.b_right = CW'($urandom);
			p.b_bottom = CW'($urandom);
			return p;
		end
		cx = ($urandom_range(0, 4) == 0) ? int'($signed(CW'($urandom))) : 0;
		cy = ($urandom_range(0, 4) == 0) ? int'($signed(CW'($urandom))) : 0;
		sz = ($urandom_range(0, 3) == 0) ? 4096 : 256;
		p.a_left = near(cx, sz);
		p.a_top = near(cy, sz);
		p.a_right = near(int'($signed(p.a_left)) + sz / 2, sz / 2);
		p.a_bottom = near(int'($signed(p.a_top)) + sz / 2, sz / 2);
		p.b_left = near(cx, sz);
		p.b_top = near(cy, sz);
		p.b_right = near(int'($signed(p.b_left)) + sz / 2, sz / 2);
		p.b_bottom = near(int'($signed(p.b_top)) + sz / 2, sz / 2);
		if (p.action == ACT_CIRCLE_CIRCLE || p.action == ACT_CIRCLE_POINT) begin
			p.a_right = near(sz / 2, sz / 2);
			p.a_bottom = CW'($urandom);
		end
		if (p.action == ACT_BOX_CIRCLE || p.action == ACT_CIRCLE_CIRCLE) begin
			p.b_right = near(sz / 2, sz / 2);
			p.b_bottom = CW'($urandom);
		end
		if (p.action == ACT_BOX_POINT || p.action == ACT_CIRCLE_POINT) begin
			p.b_right = CW'($urandom);
			p.b_bottom = CW'($urandom);
		end
		// Occasional negative radius or inverted box.
		if ($urandom_range(0, 19) == 0) p.a_right = near(-sz / 2, sz / 2);
		if ($urandom_range(0, 19) == 0) p.b_right = near(-sz / 2, sz / 2);
		return p;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is accepted.
	task automatic push_item(input shape_pair_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action = p.action;
		a_left = p.a_left;
		a_top = p.a_top;
		a_right = p.a_right;
		a_bottom = p.a_bottom;
		b_left = p.b_left;
		b_top = p.b_top;
		b_right = p.b_right;
		b_bottom = p.b_bottom;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pair(p);
		@(negedge clk);
	endtask

	task automatic directed(input logic [ACTION_WIDTH-1:0] act,
			input int al, input int at, input int ar, input int ab,
			input int bl, input int bt, input int br, input int bb);
		shape_pair_t p;
		p.action = act;
		p.a_left = al[CW-1:0];
		p.a_top = at[CW-1:0];
		p.a_right = ar[CW-1:0];
		p.a_bottom = ab[CW-1:0];
		p.b_left = bl[CW-1:0];
		p.b_top = bt[CW-1:0];
		p.b_right = br[CW-1:0];
		p.b_bottom = bb[CW-1:0];
		push_item(p);
	endtask

	task automatic random_items(input int count);
		repeat (count) push_item(make_pair());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_BOX_BOX;
		{a_left, a_top, a_right, a_bottom} = '0;
		{b_left, b_top, b_right, b_bottom} = '0;
		send_idle_pct = 18;
		recv_idle_pct = 74;
		board = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Touching edges hit, a one-step gap misses, inverted box.
		directed(ACT_BOX_BOX, 0, 0, 16, 16, 16, 0, 32, 16);
		directed(ACT_BOX_BOX, 0, 0, 16, 16, 17, 0, 32, 16);
		directed(ACT_BOX_BOX, 16, 16, 0, 0, 4, 4, 8, 8);
		// Corner distance exactly equal to the radius, then one short.
		directed(ACT_BOX_CIRCLE, 0, 0, 16, 16, 64, 80, 80, 0);
		directed(ACT_BOX_CIRCLE, 0, 0, 16, 16, 64, 80, 79, 0);
		directed(ACT_BOX_CIRCLE, 0, 0, 16, 16, 8, 8, -80, 0);
		// Centers exactly the radius sum apart do not hit.
		directed(ACT_CIRCLE_CIRCLE, 0, 0, 40, 0, 48, 64, 40, 0);
		directed(ACT_CIRCLE_CIRCLE, 0, 0, 40, 0, 48, 64, 41, 0);
		directed(ACT_CIRCLE_CIRCLE, 0, 0, -40, 0, 48, 64, -41, 0);
		// Point on an edge is outside, strictly inside is a hit.
		directed(ACT_BOX_POINT, 0, 0, 16, 16, 16, 8, 0, 0);
		directed(ACT_BOX_POINT, 0, 0, 16, 16, 8, 8, 0, 0);
		directed(ACT_CIRCLE_POINT, 0, 0, 80, 0, 48, 64, 0, 0);
		directed(ACT_CIRCLE_POINT, 0, 0, -79, 0, 48, 64, 0, 0);
		for (int c = ACT_SPARE_LO; c <= ACT_SPARE_HI; c++)
			directed(c[ACTION_WIDTH-1:0], 0, 0, 16, 16, 8, 8, 16, 16);
		// Full-scale coordinates for every test.
		for (int c = ACT_BOX_BOX; c <= ACT_CIRCLE_POINT; c++) begin
			directed(c[ACTION_WIDTH-1:0], -32768, -32768, 32767, 32767,
				32767, 32767, -32768, -32768);
			directed(c[ACTION_WIDTH-1:0], 32767, 32767, -32768, -32768,
				-32768, -32768, 32767, 32767);
		end

		random_items(133);
		send_idle_pct = 74;
		recv_idle_pct = 18;
		random_items(133);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(134);
		in_valid = 1'b0;

		while (board.pending_count() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		board.drain_leftovers();

		$display("Checked %0d results, %0d hits; box-box %0d, box-circle %0d, circle-circle %0d,",
			board.checked, board.hits_seen, board.per_action[ACT_BOX_BOX],
			board.per_action[ACT_BOX_CIRCLE], board.per_action[ACT_CIRCLE_CIRCLE]);
		$display("box-point %0d, circle-point %0d, unused codes %0d; %0d mismatches.",
			board.per_action[ACT_BOX_POINT], board.per_action[ACT_CIRCLE_POINT],
			board.per_action[5] + board.per_action[6] + board.per_action[7],
			board.mismatches);
		if (board.mismatches == 0) begin
			$display("shape_intersection_test test passed");
		end else begin
			$display("shape_intersection_test test failed");
		end
		$finish;
	end

endmodule
